// ===== rtl/rip_pkg.sv =====
// Shared types, constants and helpers for the regex infix-to-postfix converter.
package rip_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int SP_W        = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int M_TUSER_W   = 2;

    // Operator codes, equal to their precedence
    localparam logic [1:0] OP_OPEN = 2'd0;
    localparam logic [1:0] OP_ALT  = 2'd1;
    localparam logic [1:0] OP_CAT  = 2'd2;
    localparam logic [1:0] OP_STAR = 2'd3;

    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_CAT   = 8'h2E;
    localparam logic [7:0] CH_ALT   = 8'h7C;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OPEN_LEFT = 2'd1;
    localparam logic [1:0] ST_CLOSE_BAD = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic {S_IDLE, S_WORK} state_t;

    typedef enum logic [2:0] {
        CL_OPERAND, CL_OPER, CL_OPEN, CL_CLOSE, CL_END
    } cls_t;

    typedef enum logic [1:0] {SEL_SYM, SEL_TOP, SEL_CLOSE} sel_t;

    typedef struct packed {
        logic       load;
        logic       pop;
        logic       push;
        logic       replace;
        logic       set_err;
        logic [1:0] err_code;
        logic       clear;
        logic       emit;
        sel_t       sel;
        logic       last;
    } cmd_t;

    typedef struct packed {
        cls_t       cls;
        logic [1:0] code;
        logic       err;
        logic       cnt_zero;
        logic [1:0] top;
        logic       below_valid;
        logic [1:0] below;
        logic       out_free;
    } stat_t;

    function automatic logic [7:0] code_byte(input logic [1:0] code);
        logic [7:0] b;
        unique case (code)
            OP_OPEN: b = CH_OPEN;
            OP_ALT:  b = CH_ALT;
            OP_CAT:  b = CH_CAT;
            default: b = CH_STAR;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/regex_infix_to_postfix.sv =====
// Top level: regex infix-to-postfix converter (shunting-yard with operator stack).
// Timing: an accepted word is loaded into the item register and decoded in the next cycle;
// each result word is registered in the output register once it is free, then shows on m_tvalid.
// Work per item: an accept step plus a work step for each result word (a pop and its word share
// it, the final pop of an operator also takes its push), plus a step of its own for a push with
// no pop, for dropping '(' on a close and for a paren error.
// Output stalls hold the FSM, so s_tready stays low until the item is finished.
// Reset (aresetn low, synchronous): clears stack count, error latch, FSM and m_tvalid;
// stack entries are not cleared since only entries below the count are read.
module regex_infix_to_postfix (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rip_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] symbol
    input  logic                          s_tuser,  // [0] kind (1 = end of expression)
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rip_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] out_symbol, [9:8] status
    output logic [rip_pkg::M_TUSER_W-1:0] m_tuser,  // [0] has_symbol, [1] done_res
    output logic                          m_tlast   // last word caused by the input word
);
    import rip_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller: walks each item through pop / push / emit steps
    rip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: stack, error latch, output register (decouples m_tready from input)
    rip_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/rip_datapath.sv =====
// Datapath: item register, operator stack, error latch and output register.
module rip_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rip_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  rip_pkg::cmd_t                 cmd,
    output rip_pkg::stat_t                stat,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rip_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [rip_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import rip_pkg::*;

    logic             kind_reg;
    logic [7:0]       sym_reg;
    logic [1:0]       stack_mem [STACK_DEPTH];
    logic [1:0]       top_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [1:0]       err_reg, err_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_sym_reg;
    logic             m_has_reg, m_done_reg, m_last_reg;
    logic [1:0]       m_status_reg;

    logic [CNT_W-1:0] cnt_m1, cnt_m2;
    logic [SP_W-1:0]  wr_idx, rd_idx;
    logic             cnt_full;
    cls_t             cls;
    logic [1:0]       item_code;

    assign cnt_m1   = count_reg - CNT_W'(1);
    assign cnt_m2   = count_reg - CNT_W'(2);
    assign wr_idx   = cnt_m1[SP_W-1:0];
    assign rd_idx   = cnt_m2[SP_W-1:0];
    assign cnt_full = (count_reg == CNT_W'(STACK_DEPTH));

    // Item classification
    always_comb begin
        item_code = OP_OPEN;
        if (kind_reg == KIND_END) begin
            cls = CL_END;
        end else begin
            case (sym_reg)
                CH_STAR: begin cls = CL_OPER; item_code = OP_STAR; end
                CH_CAT:  begin cls = CL_OPER; item_code = OP_CAT;  end
                CH_ALT:  begin cls = CL_OPER; item_code = OP_ALT;  end
                CH_OPEN:  cls = CL_OPEN;
                CH_CLOSE: cls = CL_CLOSE;
                default:  cls = CL_OPERAND;
            endcase
        end
    end

    always_comb begin
        stat.cls         = cls;
        stat.code        = item_code;
        stat.err         = (err_reg != ST_OK);
        stat.cnt_zero    = (count_reg == '0);
        stat.top         = top_reg;
        stat.below_valid = (count_reg >= CNT_W'(2));
        stat.below       = stack_mem[rd_idx];
        stat.out_free    = !m_valid_reg || m_tready;
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg <= s_tuser;
            sym_reg  <= s_tdata;
        end
    end

    // Stack: top of stack lives in top_reg, entries below it in stack_mem
    always_ff @(posedge aclk) begin
        if (cmd.push && !cnt_full) begin
            if (count_reg != '0) begin
                stack_mem[wr_idx] <= top_reg;
            end
            top_reg <= item_code;
        end else if (cmd.replace) begin
            top_reg <= item_code;
        end else if (cmd.pop && count_reg >= CNT_W'(2)) begin
            top_reg <= stack_mem[rd_idx];
        end
    end

    always_comb begin
        count_next = count_reg;
        err_next   = err_reg;
        if (cmd.clear) begin
            count_next = '0;
            err_next   = ST_OK;
        end else begin
            if (cmd.push) begin
                if (cnt_full) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else if (cmd.pop) begin
                count_next = cnt_m1;
            end
            if (cmd.set_err) begin
                err_next = cmd.err_code;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            err_reg     <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg <= err_reg;
            m_last_reg   <= cmd.last;
            case (cmd.sel)
                SEL_SYM: begin
                    m_sym_reg  <= sym_reg;
                    m_has_reg  <= 1'b1;
                    m_done_reg <= 1'b0;
                end
                SEL_TOP: begin
                    m_sym_reg  <= code_byte(top_reg);
                    m_has_reg  <= 1'b1;
                    m_done_reg <= 1'b0;
                end
                default: begin
                    m_sym_reg  <= 8'h00;
                    m_has_reg  <= 1'b0;
                    m_done_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 10){1'b0}}, m_status_reg, m_sym_reg};
    assign m_tuser  = {m_done_reg, m_has_reg};
    assign m_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (count_reg == '0) && (err_reg == ST_OK))
        else $error("clear did not reset stack and error");

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_OK) && !cmd.clear |=> err_reg == $past(err_reg))
        else $error("latched error changed without clear");

    a_close_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_done_reg |-> m_last_reg && !m_has_reg)
        else $error("closing word without last");

endmodule

// ===== rtl/rip_ctrl.sv =====
// Controller FSM: sequences pops, pushes and result words for one item.
module rip_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rip_pkg::stat_t stat,
    output rip_pkg::cmd_t  cmd
);
    import rip_pkg::*;

    state_t state_reg, state_next;
    logic   done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.sel    = SEL_SYM;
        done       = 1'b0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = S_WORK;
                end
            end
            S_WORK: begin
                unique case (stat.cls)
                    CL_OPERAND: begin
                        if (stat.err) begin
                            done = 1'b1;
                        end else if (stat.out_free) begin
                            cmd.emit = 1'b1;
                            cmd.sel  = SEL_SYM;
                            cmd.last = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    CL_OPER: begin
                        if (stat.err) begin
                            done = 1'b1;
                        end else if (!stat.cnt_zero && stat.top > stat.code) begin
                            if (stat.out_free) begin
                                cmd.emit = 1'b1;
                                cmd.sel  = SEL_TOP;
                                cmd.last = !(stat.below_valid && stat.below > stat.code);
                                // final pop and the push collapse into a top rewrite
                                if (cmd.last) begin
                                    cmd.replace = 1'b1;
                                    done        = 1'b1;
                                end else begin
                                    cmd.pop = 1'b1;
                                end
                            end
                        end else begin
                            cmd.push = 1'b1;
                            done     = 1'b1;
                        end
                    end
                    CL_OPEN: begin
                        cmd.push = !stat.err;
                        done     = 1'b1;
                    end
                    CL_CLOSE: begin
                        if (stat.err) begin
                            done = 1'b1;
                        end else if (stat.cnt_zero) begin
                            cmd.set_err  = 1'b1;
                            cmd.err_code = ST_CLOSE_BAD;
                            done         = 1'b1;
                        end else if (stat.top == OP_OPEN) begin
                            cmd.pop = 1'b1;
                            done    = 1'b1;
                        end else if (stat.out_free) begin
                            cmd.pop  = 1'b1;
                            cmd.emit = 1'b1;
                            cmd.sel  = SEL_TOP;
                            cmd.last = !(stat.below_valid && stat.below != OP_OPEN);
                        end
                    end
                    default: begin
                        if (!stat.err && !stat.cnt_zero) begin
                            if (stat.top == OP_OPEN) begin
                                cmd.set_err  = 1'b1;
                                cmd.err_code = ST_OPEN_LEFT;
                            end else if (stat.out_free) begin
                                cmd.pop  = 1'b1;
                                cmd.emit = 1'b1;
                                cmd.sel  = SEL_TOP;
                            end
                        end else if (stat.out_free) begin
                            cmd.emit  = 1'b1;
                            cmd.sel   = SEL_CLOSE;
                            cmd.last  = 1'b1;
                            cmd.clear = 1'b1;
                            done      = 1'b1;
                        end
                    end
                endcase
                if (done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("word emitted into a full output register");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop || cmd.replace) |-> !stat.cnt_zero)
        else $error("pop on empty stack");

endmodule
